### hdl/chfa_pkg.sv
// chfa_pkg: shared constants, codes, types and the arctangent table for the
// compass heading unit. No dependencies; used by chfa_cordic and the top level.
package chfa_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	// iterations actually run, capped at the table length
	localparam int NSTEP        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	localparam int AXIS_W = 16;   // sensor sample width
	localparam int VW     = 19;   // cordic vector width, covers gain on a 17-bit vector
	localparam int ZW     = 24;   // angle accumulator width, 1/16384 degree
	localparam int AW     = 17;   // angle in 1/64 degree
	localparam int HSW    = 18;   // heading sum before wrap
	localparam int HW     = 15;   // heading output width
	localparam int DW     = 15;   // declination register width
	localparam int DIRW   = 3;    // direction register width
	localparam int IDXW   = 2;    // register index width
	localparam int ANG_SHIFT = 8;

	localparam logic signed [ZW-1:0]  ANG_180    = 24'sd2949120;
	localparam logic signed [ZW-1:0]  ROUND_HALF = 24'sd128;
	localparam logic signed [HSW-1:0] FULL_TURN  = 18'sd23040;
	localparam logic signed [DW-1:0]  DECL_LIMIT = 15'sd11520;
	localparam logic signed [DW-1:0]  DECL_RESET = 15'sd1509;

	// axis direction codes
	localparam logic [DIRW-1:0] DIR_NORTH = 3'd0;
	localparam logic [DIRW-1:0] DIR_SOUTH = 3'd1;
	localparam logic [DIRW-1:0] DIR_WEST  = 3'd2;
	localparam logic [DIRW-1:0] DIR_EAST  = 3'd3;
	localparam logic [DIRW-1:0] DIR_UP    = 3'd4;
	localparam logic [DIRW-1:0] DIR_DOWN  = 3'd5;

	// register indexes
	localparam logic [IDXW-1:0] REG_X_DIR = 2'd0;
	localparam logic [IDXW-1:0] REG_Y_DIR = 2'd1;
	localparam logic [IDXW-1:0] REG_Z_DIR = 2'd2;
	localparam logic [IDXW-1:0] REG_DECL  = 2'd3;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} vec_t;

	// atan(2^-i) in 1/16384 degree, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:  v = 24'sd737280;
			1:  v = 24'sd435242;
			2:  v = 24'sd229970;
			3:  v = 24'sd116736;
			4:  v = 24'sd58595;
			5:  v = 24'sd29326;
			6:  v = 24'sd14667;
			7:  v = 24'sd7334;
			8:  v = 24'sd3667;
			9:  v = 24'sd1833;
			10: v = 24'sd917;
			11: v = 24'sd458;
			12: v = 24'sd229;
			13: v = 24'sd115;
			14: v = 24'sd57;
			15: v = 24'sd29;
			16: v = 24'sd14;
			17: v = 24'sd7;
			18: v = 24'sd4;
			19: v = 24'sd2;
			20: v = 24'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### hdl/chfa_cordic.sv
// chfa_cordic: vectoring cordic pipeline, one iteration per register stage.
// Depends on chfa_pkg (widths, vec_t, atan_entry).
module chfa_cordic (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  chfa_pkg::vec_t in_vec,
	output logic           out_valid,
	input  logic           out_stall,
	output chfa_pkg::vec_t out_vec
);

	chfa_pkg::vec_t               vec_s2 [chfa_pkg::NSTEP];
	logic [chfa_pkg::NSTEP-1:0]   valid_s2;
	logic [chfa_pkg::NSTEP-1:0]   en;

	for (genvar k = 0; k < chfa_pkg::NSTEP; k++) begin : g_step
		chfa_pkg::vec_t src;
		chfa_pkg::vec_t nxt;
		logic           src_valid;
		logic signed [chfa_pkg::VW-1:0] dx;
		logic signed [chfa_pkg::VW-1:0] dy;

		if (k == 0) begin : g_first
			assign src       = in_vec;
			assign src_valid = in_valid;
		end else begin : g_rest
			assign src       = vec_s2[k-1];
			assign src_valid = valid_s2[k-1];
		end

		// a stage moves when it is empty or the one after it moves
		if (k == chfa_pkg::NSTEP - 1) begin : g_last
			assign en[k] = !valid_s2[k] || !out_stall;
		end else begin : g_mid
			assign en[k] = !valid_s2[k] || en[k+1];
		end

		assign dx = src.y >>> k;
		assign dy = src.x >>> k;

		always_comb begin
			nxt = src;
			if (!src.y[chfa_pkg::VW-1]) begin
				nxt.x = src.x + dx;
				nxt.y = src.y - dy;
				nxt.z = src.z + chfa_pkg::atan_entry(k);
			end else begin
				nxt.x = src.x - dx;
				nxt.y = src.y + dy;
				nxt.z = src.z - chfa_pkg::atan_entry(k);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s2[k] <= 1'b0;
			end else if (en[k]) begin
				valid_s2[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && src_valid) begin
				vec_s2[k] <= nxt;
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = valid_s2[chfa_pkg::NSTEP-1];
	assign out_vec   = vec_s2[chfa_pkg::NSTEP-1];

endmodule

### hdl/compass_heading_from_axes_unit.sv
// Compass heading unit: one magnetometer sample in, one heading in 1/64 degree out.
// An item passes these register stages in order from acceptance to output:
// one stage maps the axes to north/west and folds the left half-plane, one stage per
// cordic iteration, one stage rounds the angle and one adds declination and wraps.
// Unless stalled, a new item is accepted every cycle; each stage has its own valid bit and moves
// whenever the stage after it is empty or moving, so bubbles close up under stall.
// Depends on chfa_pkg and chfa_cordic.
module compass_heading_from_axes_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [chfa_pkg::IDXW-1:0]         cfg_index,
	input  logic [chfa_pkg::DW-1:0]           cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [chfa_pkg::AXIS_W-1:0] axis_x,
	input  logic signed [chfa_pkg::AXIS_W-1:0] axis_y,
	input  logic signed [chfa_pkg::AXIS_W-1:0] axis_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [chfa_pkg::HW-1:0]           heading
);

	localparam int NW = chfa_pkg::AXIS_W + 1;

	logic [chfa_pkg::DIRW-1:0]     x_dir_q, y_dir_q, z_dir_q;
	logic signed [chfa_pkg::DW-1:0] decl_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_dir_q <= chfa_pkg::DIR_NORTH;
			y_dir_q <= chfa_pkg::DIR_WEST;
			z_dir_q <= chfa_pkg::DIR_UP;
			decl_q  <= chfa_pkg::DECL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				chfa_pkg::REG_X_DIR: x_dir_q <= cfg_data[chfa_pkg::DIRW-1:0];
				chfa_pkg::REG_Y_DIR: y_dir_q <= cfg_data[chfa_pkg::DIRW-1:0];
				chfa_pkg::REG_Z_DIR: z_dir_q <= cfg_data[chfa_pkg::DIRW-1:0];
				chfa_pkg::REG_DECL:  decl_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage 1: axis mapping and half-plane fold
	logic signed [NW-1:0]          axv [3];
	logic [chfa_pkg::DIRW-1:0]     axd [3];
	logic signed [NW-1:0]          north, west;
	chfa_pkg::vec_t                vec_d1, vec_s1;
	logic                          valid_s1;
	logic                          en_s1;

	logic                          cd_stall, cd_valid, cd_stall_dn;
	chfa_pkg::vec_t                cd_vec;

	always_comb begin
		// z first, then y, then x, so x wins a conflict
		axv[0] = NW'(axis_z);
		axv[1] = NW'(axis_y);
		axv[2] = NW'(axis_x);
		axd[0] = z_dir_q;
		axd[1] = y_dir_q;
		axd[2] = x_dir_q;
		north  = '0;
		west   = '0;
		for (int i = 0; i < 3; i++) begin
			case (axd[i])
				chfa_pkg::DIR_NORTH: north = axv[i];
				chfa_pkg::DIR_SOUTH: north = -axv[i];
				chfa_pkg::DIR_WEST:  west  = axv[i];
				chfa_pkg::DIR_EAST:  west  = -axv[i];
				default: ;
			endcase
		end
		vec_d1.zero = (north == '0) && (west == '0);
		if (north[NW-1]) begin
			vec_d1.x = -chfa_pkg::VW'(north);
			vec_d1.y = -chfa_pkg::VW'(west);
			vec_d1.z = west[NW-1] ? -chfa_pkg::ANG_180 : chfa_pkg::ANG_180;
		end else begin
			vec_d1.x = chfa_pkg::VW'(north);
			vec_d1.y = chfa_pkg::VW'(west);
			vec_d1.z = '0;
		end
	end

	assign en_s1    = !valid_s1 || !cd_stall;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			vec_s1 <= vec_d1;
		end
	end

	chfa_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_stall  (cd_stall),
		.in_vec    (vec_s1),
		.out_valid (cd_valid),
		.out_stall (cd_stall_dn),
		.out_vec   (cd_vec)
	);

	// stage 3: round angle to 1/64 degree
	logic                          valid_s3, en_s3;
	logic signed [chfa_pkg::AW-1:0] ang_s3;
	logic signed [chfa_pkg::ZW-1:0] z_rnd, z_shr;

	assign z_rnd = cd_vec.z + chfa_pkg::ROUND_HALF;
	assign z_shr = z_rnd >>> chfa_pkg::ANG_SHIFT;

	logic valid_s4, en_s4;
	assign en_s4       = !valid_s4 || !out_stall;
	assign en_s3       = !valid_s3 || en_s4;
	assign cd_stall_dn = !en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= cd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && cd_valid) begin
			ang_s3 <= cd_vec.zero ? '0 : $signed(z_shr[chfa_pkg::AW-1:0]);
		end
	end

	// stage 4: declination and wrap into 0..360 degrees
	logic signed [chfa_pkg::DW-1:0]  decl_sat;
	logic signed [chfa_pkg::HSW-1:0] h_sum, h_wrap;
	logic [chfa_pkg::HW-1:0]         heading_s4;

	always_comb begin
		if (decl_q > chfa_pkg::DECL_LIMIT) begin
			decl_sat = chfa_pkg::DECL_LIMIT;
		end else if (decl_q < -chfa_pkg::DECL_LIMIT) begin
			decl_sat = -chfa_pkg::DECL_LIMIT;
		end else begin
			decl_sat = decl_q;
		end
		h_sum  = chfa_pkg::HSW'(ang_s3) + chfa_pkg::HSW'(decl_sat);
		h_wrap = h_sum;
		if (h_wrap < 0) begin
			h_wrap = h_wrap + chfa_pkg::FULL_TURN;
		end
		if (h_wrap > chfa_pkg::FULL_TURN) begin
			h_wrap = h_wrap - chfa_pkg::FULL_TURN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			heading_s4 <= h_wrap[chfa_pkg::HW-1:0];
		end
	end

	assign out_valid = valid_s4;
	assign heading   = heading_s4;

	// checks
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading <= chfa_pkg::HW'(chfa_pkg::FULL_TURN)))
		else $error("heading out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty first stage");

	a_fold_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !vec_s1.x[chfa_pkg::VW-1])
		else $error("folded vector has negative x");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cd_stall) |=> (valid_s1 && $stable(vec_s1)))
		else $error("first stage item changed while stalled");

endmodule

### verif/heading_checker.sv
// heading_checker: watches the register port and both item channels of the compass
// heading unit, predicts each heading and compares it. Depends on chfa_pkg.
module heading_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [chfa_pkg::IDXW-1:0] cfg_index,
	input  logic [chfa_pkg::DW-1:0]   cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic signed [chfa_pkg::AXIS_W-1:0] axis_x,
	input  logic signed [chfa_pkg::AXIS_W-1:0] axis_y,
	input  logic signed [chfa_pkg::AXIS_W-1:0] axis_z,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [chfa_pkg::HW-1:0] heading,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITERATIONS = (chfa_pkg::CORDIC_STEPS < 24) ? chfa_pkg::CORDIC_STEPS : 24;
	localparam longint HALF_TURN_FINE = 2949120;   // 180 degrees in 1/16384 degree
	localparam longint TURN_64 = 23040;            // 360 degrees in 1/64 degree
	localparam longint DECL_MAX = 11520;
	// atan(2^-i) in 1/16384 degree
	localparam longint ARCTAN_FINE [24] = '{
		737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
		3667, 1833, 917, 458, 229, 115, 57, 29,
		14, 7, 4, 2, 1, 0, 0, 0
	};

	logic [chfa_pkg::DIRW-1:0]      x_dir, y_dir, z_dir;
	logic signed [chfa_pkg::DW-1:0] decl_reg;
	logic [chfa_pkg::HW-1:0]        heading_q [$];
	int                             seen;

	function automatic logic [chfa_pkg::HW-1:0] predict_heading(
			input logic signed [chfa_pkg::AXIS_W-1:0] ax,
			input logic signed [chfa_pkg::AXIS_W-1:0] ay,
			input logic signed [chfa_pkg::AXIS_W-1:0] az);
		logic [chfa_pkg::DIRW-1:0] dir_of [3];
		longint          val_of [3];
		longint          north, west, ang, dx, dy, h, dcl;
		// z first, x last: a later axis overrides an earlier one
		dir_of[0] = z_dir;
		dir_of[1] = y_dir;
		dir_of[2] = x_dir;
		val_of[0] = az;
		val_of[1] = ay;
		val_of[2] = ax;
		north = 0;
		west = 0;
		for (int k = 0; k < 3; k++) begin
			case (dir_of[k])
				chfa_pkg::DIR_NORTH: north = val_of[k];
				chfa_pkg::DIR_SOUTH: north = -val_of[k];
				chfa_pkg::DIR_WEST:  west = val_of[k];
				chfa_pkg::DIR_EAST:  west = -val_of[k];
				default: ;
			endcase
		end
		ang = 0;
		if (north != 0 || west != 0) begin
			// left half-plane: turn by 180 first
			if (north < 0) begin
				ang = (west >= 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
				north = -north;
				west = -west;
			end
			for (int i = 0; i < ITERATIONS; i++) begin
				dx = west >>> i;
				dy = north >>> i;
				if (west >= 0) begin
					north += dx;
					west -= dy;
					ang += ARCTAN_FINE[i];
				end else begin
					north -= dx;
					west += dy;
					ang -= ARCTAN_FINE[i];
				end
			end
		end
		dcl = decl_reg;
		if (dcl > DECL_MAX)
			dcl = DECL_MAX;
		if (dcl < -DECL_MAX)
			dcl = -DECL_MAX;
		h = ((ang + 128) >>> 8) + dcl;
		if (h < 0)
			h += TURN_64;
		if (h > TURN_64)
			h -= TURN_64;
		return chfa_pkg::HW'(h);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_dir <= chfa_pkg::DIR_NORTH;
			y_dir <= chfa_pkg::DIR_WEST;
			z_dir <= chfa_pkg::DIR_UP;
			decl_reg <= chfa_pkg::DECL_RESET;
			heading_q.delete();
			errors = 0;
			pending = 0;
			seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					chfa_pkg::REG_X_DIR: x_dir <= cfg_data[chfa_pkg::DIRW-1:0];
					chfa_pkg::REG_Y_DIR: y_dir <= cfg_data[chfa_pkg::DIRW-1:0];
					chfa_pkg::REG_Z_DIR: z_dir <= cfg_data[chfa_pkg::DIRW-1:0];
					chfa_pkg::REG_DECL:  decl_reg <= cfg_data;
					default: ;
				endcase
			end
			// prediction uses the register values from before this edge
			if (in_valid && !in_stall)
				heading_q.push_back(predict_heading(axis_x, axis_y, axis_z));
			if (out_valid && !out_stall) begin
				if (heading_q.size() == 0) begin
					if (errors < 10)
						$display("heading item %0d arrived with none expected, got %0d",
							seen, heading);
					errors++;
				end else begin
					if (heading !== heading_q[0]) begin
						if (errors < 10)
							$display("heading item %0d mismatch: expected %0d, got %0d",
								seen, heading_q[0], heading);
						errors++;
					end
					void'(heading_q.pop_front());
				end
				seen++;
			end
			pending = heading_q.size();
		end
	end

endmodule

### verif/testbench.sv
// testbench: drives register writes and magnetometer samples into the compass heading
// unit with random idling on both channels. Depends on chfa_pkg, the unit and heading_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [chfa_pkg::IDXW-1:0] cfg_index = chfa_pkg::REG_X_DIR;
	logic [chfa_pkg::DW-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [chfa_pkg::AXIS_W-1:0] axis_x = '0;
	logic signed [chfa_pkg::AXIS_W-1:0] axis_y = '0;
	logic signed [chfa_pkg::AXIS_W-1:0] axis_z = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [chfa_pkg::HW-1:0] heading;
	int                      errors;
	int                      pending;

	int send_idle_pct = 26;
	int recv_stall_pct = 68;
	int send_quiet = 0;
	bit hold_req = 1'b0;

	always #6 clk = ~clk;

	compass_heading_from_axes_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(out_valid), .out_stall(out_stall), .heading(heading)
	);

	heading_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(out_valid), .out_stall(out_stall), .heading(heading),
		.errors(errors), .pending(pending)
	);

	task automatic send_sample(input int sx, input int sy, input int sz);
		if (send_quiet > 0)
			send_quiet--;
		else if ($urandom_range(0, 39) == 0)
			send_quiet = $urandom_range(10, 30);
		while (send_quiet == 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		axis_x <= chfa_pkg::AXIS_W'(sx);
		axis_y <= chfa_pkg::AXIS_W'(sy);
		axis_z <= chfa_pkg::AXIS_W'(sz);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop offering and wait until every heading is back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (chfa_pkg::NSTEP + 8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [chfa_pkg::IDXW-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= chfa_pkg::DW'(value);
		@(negedge clk);
	endtask

	// direction writes carry random junk above the 3-bit code
	task automatic apply_config(input int xd, input int yd, input int zd, input int dcl);
		write_reg(chfa_pkg::REG_X_DIR, ($urandom_range(0, 4095) << chfa_pkg::DIRW) | xd);
		write_reg(chfa_pkg::REG_Y_DIR, ($urandom_range(0, 4095) << chfa_pkg::DIRW) | yd);
		write_reg(chfa_pkg::REG_Z_DIR, ($urandom_range(0, 4095) << chfa_pkg::DIRW) | zd);
		write_reg(chfa_pkg::REG_DECL, dcl);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic int rand_axis();
		int t;
		t = $urandom_range(0, 200);
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return int'($urandom_range(0, 2)) - 1;
			3: return t - 100;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic int rand_dir();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(chfa_pkg::DIR_UP, 7);
		return $urandom_range(chfa_pkg::DIR_NORTH, chfa_pkg::DIR_EAST);
	endfunction

	function automatic int rand_declination();
		case ($urandom_range(0, 9))
			0: return 11520;
			1: return -11520;
			2: return $urandom_range(11521, 16383);
			3: return -int'($urandom_range(11521, 16384));
			4: return 0;
			default: return int'($urandom_range(0, 23040)) - 11520;
		endcase
	endfunction

	// receiver: random stalls, quiet stretches, and one long hold-off
	initial begin : receiver
		int quiet_left;
		int hold_left;
		bit hold_done;
		quiet_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = 90;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (quiet_left > 0)
					quiet_left--;
				else if ($urandom_range(0, 49) == 0)
					quiet_left = $urandom_range(10, 40);
				out_stall <= (quiet_left == 0) && ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: x north, y west, z up
		send_sample(0, 0, 0);
		send_sample(32767, 0, 0);
		send_sample(-32768, 0, 0);
		send_sample(-32768, -1, 0);
		send_sample(0, 32767, 0);
		send_sample(0, -32768, 0);
		send_sample(32767, 32767, 0);
		send_sample(-32768, -32768, -32768);
		send_sample(32767, -32768, 32767);
		send_sample(-1, -1, 0);
		send_sample(1, 1, 0);
		send_sample(-32768, 32767, 0);
		send_sample(-1, 0, 0);
		send_sample(-100, -1, 0);
		send_sample(2, -1, 0);

		// x overrides z on north, declination above range saturates
		settle();
		apply_config(chfa_pkg::DIR_SOUTH, chfa_pkg::DIR_EAST, chfa_pkg::DIR_NORTH, 16383);
		send_sample(32767, 0, 5);
		send_sample(32767, -1, 0);
		send_sample(-32768, 32767, 1000);
		send_sample(0, 0, -5000);

		// every axis ignored, declination below range
		settle();
		apply_config(7, 6, chfa_pkg::DIR_DOWN, -16384);
		send_sample(12345, -2222, 32767);
		send_sample(-32768, -32768, -32768);

		// x overrides y on west
		settle();
		apply_config(chfa_pkg::DIR_WEST, chfa_pkg::DIR_WEST, chfa_pkg::DIR_NORTH, -11520);
		send_sample(-32768, 32767, -32768);
		send_sample(1, -1, 0);
		send_sample(0, 5, 7);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 26;
					recv_stall_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_stall_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				settle();
				apply_config(rand_dir(), rand_dir(), rand_dir(), rand_declination());
				if (phase == 2 && blk == 0)
					hold_req = 1'b1;
				repeat (34) send_sample(rand_axis(), rand_axis(), rand_axis());
			end
		end

		settle();
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
